// ----- hdl/bbpa_pkg.sv -----
// ----------------------------------------------------------------------------
// bbpa_pkg: shared types and constants for the band peak analyzer
// Holds the filter coefficients, register indexes and queue entry type.
// ----------------------------------------------------------------------------
package bbpa_pkg;

  localparam int NumBands       = 8;
  localparam int CoefFracBits   = 14;
  localparam int InputShift     = 4;
  localparam int SampleWidth    = 12;

  localparam logic [1:0] RegUpdatePeriod = 2'd0;
  localparam logic [1:0] RegLevelShift   = 2'd1;
  localparam logic [1:0] RegLowestShift  = 2'd2;
  localparam logic [1:0] RegDeadzone     = 2'd3;

  // Coefficients per band (0 = lowest): b0, a1, a2; b2 equals -b0.
  function automatic logic signed [31:0] coef_b0(input int b);
    case (b)
      0: coef_b0 = 32'sd113;
      1: coef_b0 = 32'sd214;
      2: coef_b0 = 32'sd534;
      3: coef_b0 = 32'sd1324;
      4: coef_b0 = 32'sd3200;
      5: coef_b0 = 32'sd4869;
      6: coef_b0 = 32'sd6876;
      default: coef_b0 = 32'sd48140;
    endcase
  endfunction

  function automatic logic signed [31:0] coef_a1(input int b);
    case (b)
      0: coef_a1 = 32'sd32744;
      1: coef_a1 = 32'sd32718;
      2: coef_a1 = 32'sd32616;
      3: coef_a1 = 32'sd32226;
      4: coef_a1 = 32'sd30453;
      5: coef_a1 = 32'sd27716;
      6: coef_a1 = 32'sd22393;
      default: coef_a1 = -32'sd1421;
    endcase
  endfunction

  function automatic logic signed [31:0] coef_a2(input int b);
    case (b)
      0: coef_a2 = -32'sd16361;
      1: coef_a2 = -32'sd16341;
      2: coef_a2 = -32'sd16277;
      3: coef_a2 = -32'sd16119;
      4: coef_a2 = -32'sd15744;
      5: coef_a2 = -32'sd15410;
      6: coef_a2 = -32'sd15009;
      default: coef_a2 = -32'sd14458;
    endcase
  endfunction

  // One update snapshot: the eight peaks, band 0 lowest.
  typedef struct packed {
    logic [NumBands-1:0][31:0] peak;
  } snap_t;

endpackage

// ----- hdl/biquad_band_peak_analyzer_top.sv -----
// ----------------------------------------------------------------------------
// biquad_band_peak_analyzer_top: eight-band biquad peak meter
// Filters audio samples and reports LED levels once per update period.
// ----------------------------------------------------------------------------
// Throughput: one sample per cycle unless stalled; the filter bank is combinational.
// Updates closer than eight samples apart fill the two-entry queue and stall input.
// An update's first row passes the snapshot, queue and output registers; its
// eight rows then leave at one per cycle unless stalled, paced by the row sequencer.
// Reset clears filter history, peaks, counter and queue, and loads register
// defaults; no clearing pass is needed.
module biquad_band_peak_analyzer_top #(
  parameter int COEF_FRAC_BITS = bbpa_pkg::CoefFracBits,
  parameter int INPUT_SHIFT    = bbpa_pkg::InputShift
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        sample_valid_i,
  output logic        sample_stall_o,
  input  logic signed [11:0] sample_i,
  output logic        result_valid_o,
  input  logic        result_stall_i,
  output logic [2:0]  row_o,
  output logic [7:0]  level_o,
  output logic        last_o
);

  logic [15:0] period_q;
  logic [4:0]  lshift_q, lowshift_q;
  logic [7:0]  dz_q;
  logic        take, snap_valid, full, empty, pop;
  bbpa_pkg::snap_t snap, qdata;
  logic [1:0]  idx;

  assign pready = 1'b1;
  assign idx = paddr[3:2];

  // Registers sit at byte addresses 0, 4, 8 and 12.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= 16'd1800;
      lshift_q <= 5'd7;
      lowshift_q <= 5'd6;
      dz_q <= 8'd5;
    end else if (psel && penable && pwrite) begin
      case (idx)
        bbpa_pkg::RegUpdatePeriod: period_q <= pwdata[15:0];
        bbpa_pkg::RegLevelShift:   lshift_q <= pwdata[4:0];
        bbpa_pkg::RegLowestShift:  lowshift_q <= pwdata[4:0];
        bbpa_pkg::RegDeadzone:     dz_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      bbpa_pkg::RegUpdatePeriod: prdata = {16'd0, period_q};
      bbpa_pkg::RegLevelShift:   prdata = {27'd0, lshift_q};
      bbpa_pkg::RegLowestShift:  prdata = {27'd0, lowshift_q};
      default:                   prdata = {24'd0, dz_q};
    endcase
  end

  // Stall samples when the queue is full or a snapshot meets an unpopped entry.
  assign sample_stall_o = full || (snap_valid && (pop ? 1'b0 : !empty));
  assign take = sample_valid_i && !sample_stall_o;

  bbpa_front #(.COEF_FRAC_BITS(COEF_FRAC_BITS), .INPUT_SHIFT(INPUT_SHIFT)) u_front (
    .clk_i, .rst_ni, .take_i(take), .sample_i,
    .update_period_i(period_q), .snap_valid_o(snap_valid), .snap_o(snap)
  );

  bbpa_queue u_queue (
    .clk_i, .rst_ni, .push_i(snap_valid), .data_i(snap), .full_o(full),
    .empty_o(empty), .pop_i(pop), .data_o(qdata)
  );

  bbpa_back u_back (
    .clk_i, .rst_ni, .empty_i(empty), .snap_i(qdata), .pop_o(pop),
    .level_shift_i(lshift_q), .lowest_shift_i(lowshift_q), .deadzone_i(dz_q),
    .out_valid_o(result_valid_o), .out_stall_i(result_stall_i),
    .row_o, .level_o, .last_o
  );

endmodule

// ----- hdl/bbpa_front.sv -----
// ----------------------------------------------------------------------------
// bbpa_front: filter bank and peak tracker
// Runs every accepted sample through eight biquads and captures peak snapshots.
// ----------------------------------------------------------------------------
module bbpa_front #(
  parameter int COEF_FRAC_BITS = bbpa_pkg::CoefFracBits,
  parameter int INPUT_SHIFT    = bbpa_pkg::InputShift
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                take_i,
  input  logic signed [bbpa_pkg::SampleWidth-1:0] sample_i,
  input  logic [15:0]                         update_period_i,
  output logic                                snap_valid_o,
  output bbpa_pkg::snap_t                     snap_o
);

  localparam int N = bbpa_pkg::NumBands;

  logic signed [15:0] x, xd1_q, xd2_q;
  logic [N-1:0][31:0] y1_q, y2_q, pk_q, y, pk_new;
  logic [15:0] cnt_q;
  logic hit;

  // 12-bit sample shifted into a 16-bit word; high bits drop as in a 16-bit store.
  assign x = 16'(signed'(sample_i) <<< INPUT_SHIFT);
  assign hit = (cnt_q == update_period_i);

  always_comb begin
    for (int b = 0; b < N; b++) begin
      logic [31:0] acc;
      acc = 32'(32'(signed'(x)) * bbpa_pkg::coef_b0(b))
          - 32'(32'(signed'(xd2_q)) * bbpa_pkg::coef_b0(b))
          + 32'(y1_q[b] * bbpa_pkg::coef_a1(b))
          + 32'(y2_q[b] * bbpa_pkg::coef_a2(b));
      y[b] = 32'($signed(acc) >>> COEF_FRAC_BITS);
      pk_new[b] = ($signed(y[b]) > $signed(pk_q[b])) ? y[b] : pk_q[b];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xd1_q <= '0;
      xd2_q <= '0;
      y1_q <= '0;
      y2_q <= '0;
      pk_q <= '0;
      cnt_q <= '0;
      snap_valid_o <= 1'b0;
    end else begin
      snap_valid_o <= take_i && hit;
      if (take_i) begin
        xd1_q <= x;
        xd2_q <= xd1_q;
        y1_q <= y;
        y2_q <= y1_q;
        pk_q <= hit ? '0 : pk_new;
        cnt_q <= hit ? 16'd1 : cnt_q + 16'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i && hit) snap_o.peak <= pk_new;
  end

endmodule

// ----- hdl/bbpa_queue.sv -----
// ----------------------------------------------------------------------------
// bbpa_queue: two-entry snapshot queue
// Decouples the filter front from the row output sequencer.
// ----------------------------------------------------------------------------
module bbpa_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  bbpa_pkg::snap_t data_i,
  output logic            full_o,
  output logic            empty_o,
  input  logic            pop_i,
  output bbpa_pkg::snap_t data_o
);

  bbpa_pkg::snap_t mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

// ----- hdl/bbpa_back.sv -----
// ----------------------------------------------------------------------------
// bbpa_back: row sequencer
// Turns one peak snapshot into eight LED level transactions, row 0 first.
// ----------------------------------------------------------------------------
module bbpa_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  bbpa_pkg::snap_t snap_i,
  output logic            pop_o,
  input  logic [4:0]      level_shift_i,
  input  logic [4:0]      lowest_shift_i,
  input  logic [7:0]      deadzone_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [2:0]      row_o,
  output logic [7:0]      level_o,
  output logic            last_o
);

  logic [2:0]  row_q;
  logic [31:0] pk, sh;
  logic [7:0]  lvl;
  logic        fire;

  assign pk = snap_i.peak[3'd7 - row_q];
  assign sh = (row_q == 3'd7) ? (pk >> lowest_shift_i) : (pk >> level_shift_i);
  always_comb begin
    lvl = sh[7:0];
    if (row_q < 3'd6 && !(sh > 32'(deadzone_i))) lvl = 8'd0;
  end

  // The output register may load when it is empty or being taken.
  assign fire  = !empty_i && (!out_valid_o || !out_stall_i);
  assign pop_o = fire && (row_q == 3'd7);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (fire) begin
        out_valid_o <= 1'b1;
        row_q <= row_q + 3'd1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      row_o <= row_q;
      level_o <= lvl;
      last_o <= (row_q == 3'd7);
    end
  end

endmodule

// ----- hdl/bbpa_checker.sv -----
// ----------------------------------------------------------------------------
// bbpa_checker: port-level checks for the analyzer
// Watches result ordering and stall behavior on the top-level ports.
// ----------------------------------------------------------------------------
module bbpa_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       result_valid_o,
  input logic       result_stall_i,
  input logic [2:0] row_o,
  input logic       last_o
);

  a_last_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (last_o == (row_o == 3'd7))) else $error("last flag mismatch");

  a_row_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_stall_i && !last_o ##1 result_valid_o
    |-> row_o == $past(row_o) + 3'd1) else $error("row order broken");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_stall_i |=> result_valid_o && $stable(row_o))
    else $error("stalled result changed");

endmodule

bind biquad_band_peak_analyzer_top bbpa_checker u_bbpa_checker (
  .clk_i, .rst_ni, .result_valid_o, .result_stall_i, .row_o, .last_o
);

// ----- bench/tb_biquad_band_peak_analyzer_top.sv -----
// ----------------------------------------------------------------------------
// tb_biquad_band_peak_analyzer_top: self-checking bench for the band meter
// Drives sample transactions and register writes, predicts each LED row from
// an in-bench filter bank model and checks every result transaction in order.
// ----------------------------------------------------------------------------

// Holds the expected LED rows and compares result transactions against them.
class led_row_board;
  logic [2:0] exp_row[$];
  logic [7:0] exp_level[$];
  logic       exp_last[$];
  int         errors;

  function new();
    errors = 0;
  endfunction

  // Notes the eight rows that one update causes.
  function void note_rows(input logic [7:0] lv[8]);
    for (int r = 0; r < 8; r++) begin
      exp_row.push_back(r[2:0]);
      exp_level.push_back(lv[r]);
      exp_last.push_back(r == 7);
    end
  endfunction

  function void check_row(input logic [2:0] row, input logic [7:0] level,
                          input logic last);
    logic [2:0] er;
    logic [7:0] el;
    logic       et;
    if (exp_row.size() == 0) begin
      $error("unexpected result row=%0d level=%0d", row, level);
      errors++;
      return;
    end
    er = exp_row.pop_front();
    el = exp_level.pop_front();
    et = exp_last.pop_front();
    if (row !== er) begin
      $error("row: expected %0d actual %0d", er, row);
      errors++;
    end
    if (level !== el) begin
      $error("level: expected %0d actual %0d", el, level);
      errors++;
    end
    if (last !== et) begin
      $error("last: expected %0d actual %0d", et, last);
      errors++;
    end
  endfunction

  function int pending();
    return exp_row.size();
  endfunction
endclass

module tb_biquad_band_peak_analyzer_top;

  logic        clk_i;
  logic        rst_ni;
  logic        psel, penable, pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        sample_valid_i;
  logic        sample_stall_o;
  logic signed [11:0] sample_i;
  logic        result_valid_o;
  logic        result_stall_i;
  logic [2:0]  row_o;
  logic [7:0]  level_o;
  logic        last_o;

  biquad_band_peak_analyzer_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .sample_valid_i(sample_valid_i), .sample_stall_o(sample_stall_o),
    .sample_i(sample_i),
    .result_valid_o(result_valid_o), .result_stall_i(result_stall_i),
    .row_o(row_o), .level_o(level_o), .last_o(last_o)
  );

  led_row_board board = new();

  // Predictor copy of the registers and the filter state.
  logic [15:0] cfg_period;
  logic [4:0]  cfg_shift, cfg_low_shift;
  logic [7:0]  cfg_deadzone;
  logic [15:0] hist_x1, hist_x2;
  logic [31:0] hist_y1[8], hist_y2[8], peak[8];
  logic [15:0] count;

  // Stimulus controls: result stall rate, send idle rate and a long hold-off.
  int  stall_pct;
  int  holdoff_cycles;
  int  send_idle_pct;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Safety net: far above the slowest legal run.
  initial begin
    #2000000;
    $display("[biquad_band_peak_analyzer_top] ERROR");
    $finish;
  end

  function automatic logic signed [31:0] coef(input int b, input int k);
    case (k)
      0: coef = bbpa_pkg::coef_b0(b);
      1: coef = -bbpa_pkg::coef_b0(b);
      2: coef = bbpa_pkg::coef_a1(b);
      default: coef = bbpa_pkg::coef_a2(b);
    endcase
  endfunction

  // Filter bank and peak meter for one accepted sample.
  task automatic predict_sample(input logic signed [11:0] s);
    logic signed [15:0] x;
    logic signed [31:0] acc, yv[8];
    logic [31:0] pk, lv;
    logic [7:0]  lvls[8];
    x = 16'(s) <<< bbpa_pkg::InputShift;
    for (int b = 0; b < 8; b++) begin
      acc = 32'(x) * coef(b, 0) + 32'($signed(hist_x2)) * coef(b, 1)
          + $signed(hist_y1[b]) * coef(b, 2) + $signed(hist_y2[b]) * coef(b, 3);
      yv[b] = acc >>> bbpa_pkg::CoefFracBits;
      if (yv[b] > $signed(peak[b])) peak[b] = yv[b];
    end
    if (count == cfg_period) begin
      for (int r = 0; r < 8; r++) begin
        pk = peak[7 - r];
        if (r == 7) lv = pk >> cfg_low_shift;
        else begin
          lv = pk >> cfg_shift;
          if (r < 6 && !(lv > cfg_deadzone)) lv = 0;
        end
        lvls[r] = lv[7:0];
      end
      board.note_rows(lvls);
      for (int b = 0; b < 8; b++) peak[b] = '0;
      count = '0;
    end
    hist_x2 = hist_x1;
    hist_x1 = x;
    for (int b = 0; b < 8; b++) begin
      hist_y2[b] = hist_y1[b];
      hist_y1[b] = yv[b];
    end
    count = count + 16'd1;
  endtask

  // Setup and access phases of one register write; only while idle.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      bbpa_pkg::RegUpdatePeriod: cfg_period    = value[15:0];
      bbpa_pkg::RegLevelShift:   cfg_shift     = value[4:0];
      bbpa_pkg::RegLowestShift:  cfg_low_shift = value[4:0];
      default:                   cfg_deadzone  = value[7:0];
    endcase
  endtask

  task automatic program_all(input logic [31:0] per, input logic [31:0] sh,
                             input logic [31:0] lsh, input logic [31:0] dz);
    write_reg(bbpa_pkg::RegUpdatePeriod, per);
    write_reg(bbpa_pkg::RegLevelShift, sh);
    write_reg(bbpa_pkg::RegLowestShift, lsh);
    write_reg(bbpa_pkg::RegDeadzone, dz);
  endtask

  // Offers one sample transaction, with an optional random gap first, and
  // holds it until accepted.
  task automatic send_sample(input logic signed [11:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    sample_valid_i <= 1'b1;
    sample_i <= s;
    @(posedge clk_i);
    while (sample_stall_o) @(posedge clk_i);
    predict_sample(s);
  endtask

  // Waits for all expected rows, then for the block's pipeline to drain.
  task automatic drain();
    sample_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  function automatic logic signed [11:0] rand_sample();
    case ($urandom_range(5))
      0: rand_sample = 12'sh7FF;
      1: rand_sample = 12'sh800;
      default: rand_sample = 12'($urandom);
    endcase
  endfunction

  // Result side: checks accepted rows; random stalls plus a requested long hold-off.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_stall_i <= 1'b1;
    end else begin
      if (result_valid_o && !result_stall_i) board.check_row(row_o, level_o, last_o);
      if (holdoff_cycles > 0) begin
        holdoff_cycles <= holdoff_cycles - 1;
        result_stall_i <= 1'b1;
      end else begin
        result_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    sample_valid_i = 1'b0; sample_i = '0;
    stall_pct = 15; send_idle_pct = 15; holdoff_cycles = 0;
    cfg_period = 16'd1800; cfg_shift = 5'd7; cfg_low_shift = 5'd6;
    cfg_deadzone = 8'd5;
    hist_x1 = '0; hist_x2 = '0; count = '0;
    for (int b = 0; b < 8; b++) begin
      hist_y1[b] = '0; hist_y2[b] = '0; peak[b] = '0;
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: update every sample, full-scale steps, small shifts so
    // the deadzone matters; out-of-range values check register masking.
    program_all(32'h0001_0001, 32'd0, 32'd0, 32'd0);
    for (int i = 0; i < 6; i++) send_sample(i[0] ? 12'sh7FF : 12'sh800);
    drain();
    program_all(32'd2, 32'd31, 32'd31, 32'd255);
    for (int i = 0; i < 6; i++) send_sample(rand_sample());
    drain();
    program_all(32'd3, 32'd4, 32'd2, 32'd20);
    for (int i = 0; i < 8; i++) send_sample(12'sh7FF);
    send_sample(12'sd0);
    send_sample(-12'sd1);
    drain();

    // Counter past the period: a period below the running count is hit only after
    // the counter wraps, which the short random burst that follows does not reach.
    program_all(32'd1, 32'd9, 32'd5, 32'd3);
    for (int i = 0; i < 40; i++) send_sample(rand_sample());
    drain();

    // Pressure: restart the counter with one update, then update on every
    // sample while the receiver holds off and samples keep coming.
    program_all({16'd0, count}, 32'd6, 32'd3, 32'd1);
    send_sample(rand_sample());
    drain();
    program_all(32'd1, 32'd6, 32'd3, 32'd1);
    holdoff_cycles = 300;
    send_idle_pct = 0;
    for (int i = 0; i < 60; i++) send_sample(rand_sample());
    drain();

    // Random phases with varied settings; one phase runs with no idling.
    for (int ph = 0; ph < 5; ph++) begin
      program_all($urandom_range(6), $urandom_range(31), $urandom_range(31),
                  $urandom_range(255));
      stall_pct = (ph == 2) ? 0 : 15;
      send_idle_pct = (ph == 2) ? 0 : 15;
      for (int i = 0; i < 56; i++) send_sample(rand_sample());
      drain();
    end
    program_all(32'd1800, 32'd7, 32'd6, 32'd5);
    for (int i = 0; i < 10; i++) send_sample(rand_sample());
    drain();

    if (board.errors == 0 && board.pending() == 0) begin
      $display("[biquad_band_peak_analyzer_top] OK");
    end else begin
      $display("[biquad_band_peak_analyzer_top] ERROR");
    end
    $finish;
  end
endmodule

// ----- biquad_band_peak_analyzer_top.f -----
hdl/bbpa_pkg.sv
hdl/bbpa_front.sv
hdl/bbpa_queue.sv
hdl/bbpa_back.sv
hdl/biquad_band_peak_analyzer_top.sv
hdl/bbpa_checker.sv
bench/tb_biquad_band_peak_analyzer_top.sv
